FILE: hdl/flcsr_pkg.sv
// shared types, register constants and status update functions of the flash register window
`timescale 1ns / 1ps

package flcsr_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [31:0] t_word;
    typedef logic [3:0]  t_lanes;

    // access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic [11:0] CTRL_OFF    = 12'h000;
    localparam logic [11:0] STAT_OFF    = 12'h004;
    localparam t_word       CTRL_ENABLE = 32'h0000_0001;
    localparam t_word       STAT_GOOD   = 32'h0000_4000;
    localparam t_word       STAT_DONE   = 32'h0000_8000;
    localparam t_word       STAT_PE_ERR = 32'h0003_0000;
    localparam t_word       STAT_W1C    = 32'hF313_0000;

    // byte lanes to a bit mask
    function automatic t_word lane_mask(input t_lanes lanes);
        return {{8{lanes[3]}}, {8{lanes[2]}}, {8{lanes[1]}}, {8{lanes[0]}}};
    endfunction

    // status after a control word write
    function automatic t_word ctrl_update(input logic was_on, input logic is_on,
                                          input t_word st);
        t_word res;
        res = st;
        if (was_on && !is_on) begin
            res = res | STAT_DONE;
            if ((res & STAT_PE_ERR) == 32'h0) begin
                res = res | STAT_GOOD;
            end else begin
                res = res & ~STAT_GOOD;
            end
        end else if (!was_on && !is_on) begin
            res = res | STAT_DONE | STAT_GOOD;
        end
        return res;
    endfunction

    // status after a status word write, starting from the value before the write
    function automatic t_word stat_update(input t_word old_st, input t_word mask,
                                          input t_word written);
        t_word res;
        res = (old_st & ~(written & mask & STAT_W1C)) | STAT_DONE;
        if ((res & STAT_W1C) == 32'h0) begin
            res = res | STAT_GOOD;
        end else begin
            res = res & ~STAT_GOOD;
        end
        return res;
    endfunction

endpackage

FILE: hdl/flcsr_ram.sv
// single-port byte memory with registered read data
`timescale 1ns / 1ps

module flcsr_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_addr,
    input  flcsr_pkg::t_byte     i_wdata,
    output flcsr_pkg::t_byte     o_rdata
);

    flcsr_pkg::t_byte r_mem [DEPTH];
    flcsr_pkg::t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/flash_control_status_registers_top.sv
// flash control and status register window, byte-serial access sequencer
`timescale 1ns / 1ps

// Register window of WINDOW_BYTES bytes, little endian, byte addressed.
// Input channel (i_in_valid / o_in_ready) carries one access item: kind,
// address, access_size (1 to 4) and write_data. Output channel
// (o_out_valid / i_out_ready) returns one item per access: read_data and
// access_error. Accesses past the window or with a bad size come back with
// access_error set and read_data zero. The sequencer moves one byte per
// step through a single memory port: a read passes through an address
// state and a data state for each byte, a write through a write state for
// each byte and then a status update state. The control and status words
// live in flip-flops.
// After reset the memory is swept to zero, one byte a cycle, so o_in_ready
// stays low until the sweep ends; status starts with done and good set.
// A finished item sits in the output register; the next item is accepted
// meanwhile, and the sequencer waits at its end until the output is free.
module flash_control_status_registers_top #(
    parameter int WINDOW_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [11:0] i_address,
    input  logic [2:0]  i_access_size,
    input  logic [31:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic        o_access_error
);

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam int PW = (AW > 12) ? AW : 12;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_RADDR  = 3'd2;
    localparam logic [2:0] ST_RDATA  = 3'd3;
    localparam logic [2:0] ST_WRITE  = 3'd4;
    localparam logic [2:0] ST_UPDATE = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic        r_kind, n_kind;
    logic [11:0] r_ptr, n_ptr;
    logic [2:0]  r_cnt, n_cnt;
    logic [1:0]  r_lane, n_lane;
    logic [31:0] r_wdata, n_wdata;
    logic [31:0] r_acc, n_acc;
    logic        r_err, n_err;
    flcsr_pkg::t_word  r_ctrl, n_ctrl;
    flcsr_pkg::t_word  r_stat, n_stat;
    flcsr_pkg::t_word  r_old_ctrl, n_old_ctrl;
    flcsr_pkg::t_word  r_old_stat, n_old_stat;
    flcsr_pkg::t_lanes r_ctrl_lanes, n_ctrl_lanes;
    flcsr_pkg::t_lanes r_stat_lanes, n_stat_lanes;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_data, n_out_data;
    logic        r_out_err, n_out_err;

    logic              in_accept;
    logic              bad_access;
    logic [16:0]       end_addr;
    logic [PW-1:0]     ptr_wide;
    logic [AW-1:0]     ptr_idx;
    logic              ptr_low;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    flcsr_pkg::t_byte  ram_wdata;
    flcsr_pkg::t_byte  ram_rdata;
    flcsr_pkg::t_byte  rd_byte;

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign end_addr   = {5'b0, i_address} + {14'b0, i_access_size};
    assign bad_access = (i_access_size == 3'd0) || (i_access_size > 3'd4) ||
                        (end_addr > 17'(WINDOW_BYTES));
    assign ptr_wide   = PW'(r_ptr);
    assign ptr_idx    = ptr_wide[AW-1:0];
    // the first two words are held in flip-flops
    assign ptr_low    = (r_ptr[11:3] == 9'd0);

    always_comb begin
        if (ptr_low) begin
            if (r_ptr[2]) begin
                rd_byte = r_stat[{r_ptr[1:0], 3'b000} +: 8];
            end else begin
                rd_byte = r_ctrl[{r_ptr[1:0], 3'b000} +: 8];
            end
        end else begin
            rd_byte = ram_rdata;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_kind       = r_kind;
        n_ptr        = r_ptr;
        n_cnt        = r_cnt;
        n_lane       = r_lane;
        n_wdata      = r_wdata;
        n_acc        = r_acc;
        n_err        = r_err;
        n_ctrl       = r_ctrl;
        n_stat       = r_stat;
        n_old_ctrl   = r_old_ctrl;
        n_old_stat   = r_old_stat;
        n_ctrl_lanes = r_ctrl_lanes;
        n_stat_lanes = r_stat_lanes;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_data   = r_out_data;
        n_out_err    = r_out_err;
        ram_we       = 1'b0;
        ram_addr     = ptr_idx;
        ram_wdata    = r_wdata[7:0];
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = 8'h00;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(WINDOW_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_kind       = i_kind;
                    n_ptr        = i_address;
                    n_cnt        = i_access_size;
                    n_lane       = 2'd0;
                    n_wdata      = i_write_data;
                    n_acc        = 32'h0;
                    n_err        = bad_access;
                    n_old_ctrl   = r_ctrl;
                    n_old_stat   = r_stat;
                    n_ctrl_lanes = '0;
                    n_stat_lanes = '0;
                    if (bad_access) begin
                        n_state = ST_FINISH;
                    end else if (i_kind == flcsr_pkg::KIND_WRITE) begin
                        n_state = ST_WRITE;
                    end else begin
                        n_state = ST_RADDR;
                    end
                end
            end
            ST_RADDR: begin
                n_state = ST_RDATA;
            end
            ST_RDATA: begin
                n_acc  = r_acc | ({24'h0, rd_byte} << {r_lane, 3'b000});
                n_lane = r_lane + 1'b1;
                n_ptr  = r_ptr + 1'b1;
                n_cnt  = r_cnt - 1'b1;
                n_state = (r_cnt == 3'd1) ? ST_FINISH : ST_RADDR;
            end
            ST_WRITE: begin
                ram_we = 1'b1;
                if (ptr_low) begin
                    if (r_ptr[2]) begin
                        n_stat[{r_ptr[1:0], 3'b000} +: 8] = r_wdata[7:0];
                        n_stat_lanes[r_ptr[1:0]]         = 1'b1;
                    end else begin
                        n_ctrl[{r_ptr[1:0], 3'b000} +: 8] = r_wdata[7:0];
                        n_ctrl_lanes[r_ptr[1:0]]         = 1'b1;
                    end
                end
                n_wdata = {8'h00, r_wdata[31:8]};
                n_ptr   = r_ptr + 1'b1;
                n_cnt   = r_cnt - 1'b1;
                n_state = (r_cnt == 3'd1) ? ST_UPDATE : ST_WRITE;
            end
            ST_UPDATE: begin
                // a status write overrides the control update
                if (r_stat_lanes != '0) begin
                    n_stat = flcsr_pkg::stat_update(r_old_stat,
                                                    flcsr_pkg::lane_mask(r_stat_lanes),
                                                    r_stat);
                end else if (r_ctrl_lanes != '0) begin
                    n_stat = flcsr_pkg::ctrl_update(
                        (r_old_ctrl & flcsr_pkg::CTRL_ENABLE) != 32'h0,
                        (r_ctrl & flcsr_pkg::CTRL_ENABLE) != 32'h0, r_stat);
                end
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = (r_kind == flcsr_pkg::KIND_WRITE) ? 32'h0 : r_acc;
                    n_out_err   = r_err;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_ctrl      <= 32'h0;
            r_stat      <= flcsr_pkg::STAT_DONE | flcsr_pkg::STAT_GOOD;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_ctrl      <= n_ctrl;
            r_stat      <= n_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_ptr        <= n_ptr;
        r_cnt        <= n_cnt;
        r_lane       <= n_lane;
        r_wdata      <= n_wdata;
        r_acc        <= n_acc;
        r_err        <= n_err;
        r_old_ctrl   <= n_old_ctrl;
        r_old_stat   <= n_old_stat;
        r_ctrl_lanes <= n_ctrl_lanes;
        r_stat_lanes <= n_stat_lanes;
        r_out_data   <= n_out_data;
        r_out_err    <= n_out_err;
    end

    flcsr_ram #(
        .DEPTH (WINDOW_BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_out_data;
    assign o_access_error = r_out_err;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_in_ready)
        else $error("input accepted while an item is in progress");

    // status bytes may hold raw write data until the update step
    a_done_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ((r_stat & flcsr_pkg::STAT_DONE) != 32'h0))
        else $error("status done bit cleared");

    a_error_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_access_error) |-> (o_read_data == 32'h0))
        else $error("rejected access returned nonzero data");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!o_in_ready && !o_out_valid))
        else $error("channel active during memory sweep");

endmodule
